// ===== rtl/core/ecdf_pkg.sv =====
// Package: types, sizes and opcodes for the empirical CDF table.
`default_nettype none
package ecdf_pkg;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CNT_W = 11;
  localparam int FRAC_W = 17;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]   rank;
    logic [FRAC_W-1:0]  fraction;
    logic signed [31:0] left_margin;
    logic signed [31:0] right_margin;
    logic [CNT_W-1:0]   sample_count;
    logic               full_error;
    logic               empty_flag;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/core/ecdf_div.sv =====
// Restoring divider: (rank << 16) / n, one quotient bit per cycle.
`default_nettype none
module ecdf_div import ecdf_pkg::*; #(
  parameter int CW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW-1:0] num_rank,
  input  wire logic [CW-1:0] den,
  output logic               done,
  output logic [FRAC_W-1:0]  quot
);
  localparam int NB = CW + 16;
  localparam int SW = $clog2(NB + 1);

  logic [NB-1:0]   num_r, num_nxt;
  logic [CW:0]     rem_r, rem_nxt;
  logic [NB-1:0]   q_r, q_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [CW:0]     trial;
  logic [CW-1:0]   den_r, den_nxt;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    den_nxt = den_r;
    done = 1'b0;
    trial = {rem_r[CW-1:0], num_r[NB-1]};
    if (start) begin
      num_nxt = {num_rank, 16'd0};
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = SW'(NB);
      busy_nxt = 1'b1;
      den_nxt = den;
    end else if (busy_r) begin
      num_nxt = {num_r[NB-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
  end

  assign quot = FRAC_W'(q_nxt);
endmodule
`default_nettype wire

// ===== rtl/core/empirical_cdf_table.sv =====
// Top level: sorted sample table with rank, fraction and margin queries.
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | in_word  (in_word_t)
// out     | out | out_valid / out_ready | out_word (out_word_t)
//
// Steps from acceptance to out_valid: clear goes straight to the output; insert
// does a linear rank scan, then moves each entry above the rank up one place;
// query does a linear rank scan, forward and backward margin walks and a
// division. Refused insert and empty query go straight to the output.
// Reset empties the table; memory contents need no clearing.
// in_ready is low from acceptance until the result word has been taken.
`default_nettype none
module empirical_cdf_table import ecdf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = CW + 10;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RANK  = 9'b000000010,
    S_SHIFT = 9'b000000100,
    S_PUT   = 9'b000001000,
    S_LEFT  = 9'b000010000,
    S_RIGHT = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r, x_r, x_nxt, lm_r, lm_nxt, rm_r, rm_nxt;
  logic [CW-1:0] n_r, n_nxt, idx_r, idx_nxt, rank_r, rank_nxt, pos_r, pos_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic          rv_r, rv_nxt, found_r, found_nxt;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic signed [SAMPLE_BITS-1:0] wdata;
  logic [1:0]    op_r, op_nxt;
  logic          full_r, full_nxt;
  out_word_t     ow_r, ow_nxt;
  logic          ov_r, ov_nxt;
  logic          div_start, div_done;
  logic [FRAC_W-1:0] quot;
  logic [PW-1:0] thr_l, thr_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  ecdf_div #(.CW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num_rank(rank_r),
    .den(n_r), .done(div_done), .quot(quot)
  );

  assign thr_l = PW'(n_r);
  assign thr_r = PW'(n_r) * PW'(999);
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_word = ow_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; idx_nxt = idx_r; rank_nxt = rank_r; pos_nxt = pos_r;
    run_nxt = run_r; rv_nxt = rv_r; found_nxt = found_r;
    x_nxt = x_r; lm_nxt = lm_r; rm_nxt = rm_r; op_nxt = op_r;
    full_nxt = full_r; ow_nxt = ow_r; ov_nxt = ov_r;
    raddr = AW'(idx_r); we = 1'b0; waddr = AW'(idx_r); wdata = x_r;
    div_start = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (in_valid && in_ready) begin
          op_nxt = in_word.operation;
          x_nxt = SAMPLE_BITS'(in_word.value);
          if (SAMPLE_BITS > 32)
            x_nxt = SAMPLE_BITS'(signed'(in_word.value));
          full_nxt = 1'b0;
          idx_nxt = '0; rank_nxt = '0; rv_nxt = 1'b0;
          case (in_word.operation)
            OP_CLEAR: begin n_nxt = '0; state_nxt = S_OUT; end
            OP_INSERT: begin
              if (n_r >= CW'(TABLE_DEPTH)) begin
                full_nxt = 1'b1; state_nxt = S_OUT;
              end else state_nxt = S_RANK;
            end
            OP_QUERY: state_nxt = (n_r == '0) ? S_OUT : S_RANK;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RANK: begin
        // linear scan: rank = count of samples <= x
        raddr = AW'(idx_r + 1'b1);
        if (!rv_r) begin
          raddr = AW'(idx_r);
          rv_nxt = (idx_r < n_r);
          if (idx_r >= n_r) rv_nxt = 1'b0;
          if (idx_r >= n_r) begin
            rank_nxt = idx_r;
            pos_nxt = idx_r;
            idx_nxt = n_r;
            state_nxt = (op_r == OP_INSERT) ? S_SHIFT : S_LEFT;
            rv_nxt = 1'b0;
            if (op_r != OP_INSERT) begin idx_nxt = '0; run_nxt = '0; found_nxt = 1'b0;
              lm_nxt = x_r; end
          end
        end else if (rd_r > x_r) begin
          rank_nxt = idx_r; pos_nxt = idx_r; rv_nxt = 1'b0;
          state_nxt = (op_r == OP_INSERT) ? S_SHIFT : S_LEFT;
          idx_nxt = (op_r == OP_INSERT) ? n_r : '0;
          run_nxt = '0; found_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rv_nxt = (idx_r + 1'b1) < n_r;
          if ((idx_r + 1'b1) >= n_r) begin
            rank_nxt = n_r; pos_nxt = n_r; rv_nxt = 1'b0;
            state_nxt = (op_r == OP_INSERT) ? S_SHIFT : S_LEFT;
            idx_nxt = (op_r == OP_INSERT) ? n_r : '0;
            run_nxt = '0; found_nxt = 1'b0;
          end
        end
      end
      S_SHIFT: begin
        // move mem[idx-1] to mem[idx] down to pos
        raddr = AW'(idx_r - 1'b1);
        if (idx_r == pos_r) state_nxt = S_PUT;
        else if (!rv_r) rv_nxt = 1'b1;
        else begin
          we = 1'b1; waddr = AW'(idx_r); wdata = rd_r;
          idx_nxt = idx_r - 1'b1; rv_nxt = 1'b0;
        end
      end
      S_PUT: begin
        we = 1'b1; waddr = AW'(pos_r); wdata = x_r;
        n_nxt = n_r + 1'b1; state_nxt = S_OUT;
      end
      S_LEFT: begin
        // forward walk; rank of mem[i] is end of its equal run
        raddr = AW'(idx_r);
        if (!rv_r) begin
          rv_nxt = 1'b1;
        end else begin
          // lm_r holds the candidate (run start value) when found_r
          if (idx_r == '0 || rd_r != lm_r || !found_r) begin
            // rd_r starts or continues; track run by comparing to previous
          end
          rv_nxt = 1'b0;
          idx_nxt = idx_r + 1'b1;
          found_nxt = 1'b1;
          if (found_r && rd_r != lm_r) begin
            // previous run ended at idx_r: its rank is idx_r
            if (PW'(idx_r) * PW'(1000) > thr_l) begin
              state_nxt = S_RIGHT; idx_nxt = n_r - 1'b1; rm_nxt = lm_r;
              found_nxt = 1'b0; run_nxt = '0;
            end else lm_nxt = rd_r;
          end else lm_nxt = rd_r;
          if (!(found_r && rd_r != lm_r && PW'(idx_r) * PW'(1000) > thr_l)
              && (idx_r + 1'b1) == n_r) begin
            // last run rank is n, n*1000 > n always
            state_nxt = S_RIGHT; idx_nxt = n_r - 1'b1; found_nxt = 1'b0;
            run_nxt = '0;
            rm_nxt = (found_r && rd_r != lm_r) ? rd_r : rd_r;
          end
        end
      end
      S_RIGHT: begin
        // backward walk from top to index 1; rank of mem[i] = run end + 1
        raddr = AW'(idx_r);
        if (!rv_r) begin
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
          if (!found_r || rd_r != x_r) begin
            run_nxt = idx_r + 1'b1;
          end
          if (!found_r) begin
            // remember top sample as fallback right margin
            ow_nxt.right_margin = 32'(rd_r);
          end
          found_nxt = 1'b1;
          x_nxt = rd_r;
          idx_nxt = idx_r - 1'b1;
          if (idx_r == '0) state_nxt = S_DIV;
          else if (PW'((!found_r || rd_r != x_r) ? idx_r + 1'b1 : run_r) * PW'(1000)
                   < thr_r) begin
            ow_nxt.right_margin = 32'(rd_r);
            state_nxt = S_DIV;
          end else if (idx_r == CW'(1)) state_nxt = S_DIV;
          if (state_nxt == S_DIV) div_start = 1'b1;
        end
      end
      S_DIV: if (div_done) begin
        ow_nxt.fraction = quot; state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_OUT;
      S_OUT: begin
        ow_nxt.sample_count = CNT_W'(n_r);
        ow_nxt.full_error = full_r;
        ow_nxt.empty_flag = (op_r == OP_QUERY) && (n_r == '0);
        if (!(op_r == OP_QUERY && n_r != '0)) begin
          ow_nxt.rank = '0; ow_nxt.fraction = '0;
          ow_nxt.left_margin = '0; ow_nxt.right_margin = '0;
        end else begin
          ow_nxt.rank = CNT_W'(rank_r);
          ow_nxt.left_margin = 32'(rm_r);
        end
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; n_r <= '0; ov_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; n_r <= n_nxt; ov_r <= ov_nxt; rv_r <= rv_nxt;
    end
    idx_r <= idx_nxt; rank_r <= rank_nxt; pos_r <= pos_nxt; run_r <= run_nxt;
    found_r <= found_nxt; x_r <= x_nxt; lm_r <= lm_nxt; rm_r <= rm_nxt;
    op_r <= op_nxt; full_r <= full_nxt; ow_r <= ow_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/ecdf_checker.sv =====
// Port checker for the empirical CDF table, bound to the top level.
`default_nettype none
module ecdf_checker import ecdf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.full_error && out_word.empty_flag))
    else $error("full and empty flags together");
endmodule

bind empirical_cdf_table ecdf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
`default_nettype wire
